// File: rtl/core/triangle_scanline_filler_assert.svh
// ----------------------------------------------------------------------------
// triangle_scanline_filler_assert.svh
// Assertion macros used by the checker of the triangle scanline filler.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SCANLINE_FILLER_ASSERT_SVH
`define TRIANGLE_SCANLINE_FILLER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define TSF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define TSF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_pkg
// Types and constants shared by the triangle scanline filler modules.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int SPAN_MIN_W     = 11;
  localparam int COLOR_W        = 24;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [SPAN_MIN_W-1:0] SPAN_START_RESET = 11'd800;

  // Register indexes on the configuration port.
  localparam int REG_SPAN_MIN_START = 0;

  // Item commands.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Edge selection codes, one per triangle side.
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_AC = 2'd1;
  localparam logic [1:0] EDGE_BC = 2'd2;

  // Status returned by the edge unit.
  typedef struct packed {
    logic done;
    logic hit;
  } edge_rsp_t;

endpackage

// File: rtl/core/tsf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_div
// Restoring unsigned divider, one quotient bit per cycle. The caller
// guarantees that the quotient fits in W bits.
// ----------------------------------------------------------------------------
module tsf_div #(
  parameter int W = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*W-1:0] dividend,
  input  logic [W-1:0]   divisor,
  output logic           done,
  output logic [W-1:0]   quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     low;
  logic [W-1:0]     dvs;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       geq;

  always_comb begin
    shifted = {rem, low[W-1]};
    geq     = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  // The low register holds the dividend bits still to come and collects
  // the quotient bits from the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend[2*W-1:W];
        low  <= dividend[W-1:0];
        dvs  <= divisor;
        cnt  <= CNT_W'(W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= geq ? diff[W-1:0] : shifted[W-1:0];
        low <= {low[W-2:0], geq};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = low;

endmodule

// File: rtl/core/tsf_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_edge
// Shared edge unit: tests whether one triangle side spans a row and, if so,
// interpolates its x with one multiply and an iterative signed division.
// ----------------------------------------------------------------------------
module tsf_edge
  import tsf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] xa,
  input  logic signed [COORD_BITS-1:0] ya,
  input  logic signed [COORD_BITS-1:0] xb,
  input  logic signed [COORD_BITS-1:0] yb,
  input  logic signed [COORD_BITS-1:0] y,
  output edge_rsp_t                    rsp,
  output logic signed [COORD_BITS-1:0] x
);

  localparam int CW  = COORD_BITS;
  localparam int CW1 = COORD_BITS + 1;
  localparam int PW  = 2 * COORD_BITS + 2;

  typedef enum logic [1:0] {
    E_IDLE,
    E_MUL,
    E_DIVGO,
    E_DIVWAIT
  } edge_state_t;

  edge_state_t state;

  logic signed [CW1-1:0] dx;
  logic signed [CW1-1:0] t;
  logic signed [CW-1:0]  x0;
  logic [CW-1:0]         dy_mag;
  logic                  dy_neg;
  logic                  neg;
  logic signed [PW-1:0]  prod;

  logic signed [CW-1:0]  ylo;
  logic signed [CW-1:0]  yhi;
  logic                  spans;
  logic signed [CW1-1:0] dy_full;
  logic signed [CW1-1:0] dy_abs;
  logic signed [PW-1:0]  prod_abs;
  logic                  div_done;
  logic [CW-1:0]         quot;
  logic signed [CW1-1:0] q_ext;
  logic signed [CW1-1:0] q_signed;
  logic signed [CW1-1:0] x_sum;

  always_comb begin
    ylo      = (ya < yb) ? ya : yb;
    yhi      = (ya < yb) ? yb : ya;
    spans    = (ya != yb) && (y >= ylo) && (y <= yhi);
    dy_full  = CW1'(yb) - CW1'(ya);
    dy_abs   = dy_full[CW1-1] ? -dy_full : dy_full;
    prod_abs = prod[PW-1] ? -prod : prod;
    q_ext    = CW1'({1'b0, quot});
    q_signed = neg ? -q_ext : q_ext;
    x_sum    = CW1'(x0) + q_signed;
  end

  // Magnitudes go through the divider, so the quotient truncates toward zero.
  tsf_div #(
    .W(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == E_DIVGO),
    .dividend (prod_abs[2*CW-1:0]),
    .divisor  (dy_mag),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      rsp.done <= 1'b0;
      rsp.hit  <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (start) begin
            dx     <= CW1'(xb) - CW1'(xa);
            t      <= CW1'(y) - CW1'(ya);
            x0     <= xa;
            dy_mag <= dy_abs[CW-1:0];
            dy_neg <= dy_full[CW1-1];
            if (spans) begin
              state <= E_MUL;
            end else begin
              rsp.done <= 1'b1;
              rsp.hit  <= 1'b0;
            end
          end
        end
        E_MUL: begin
          prod  <= PW'(dx) * PW'(t);
          state <= E_DIVGO;
        end
        E_DIVGO: begin
          neg   <= prod[PW-1] ^ dy_neg;
          state <= E_DIVWAIT;
        end
        E_DIVWAIT: begin
          if (div_done) begin
            x        <= x_sum[CW-1:0];
            rsp.done <= 1'b1;
            rsp.hit  <= 1'b1;
            state    <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/triangle_scanline_filler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_scanline_filler
// Scanline fill of one triangle, one pixel per step transfer.
// ----------------------------------------------------------------------------
// Usage: a start transfer (cmd = CMD_START) on the item channel loads three
// vertices and a color and produces no result; the next item can follow in the next
// cycle. Each step transfer produces one result: the next pixel of the
// filled triangle, row by row from the lowest to the highest y, or a done
// result once no pixels remain. The block works on one item at a time and
// item_ready is high only when idle.
// A step inside a loaded span passes through S_WORK into the output register
// and frees the input in the same cycle as its result appears. A step that
// opens a row first sets up the span search in S_WORK and then runs the
// three sides through the shared edge unit; rows that no side crosses
// repeat this.
// The result sits in an output register until result_ready takes it. During a
// stall the block keeps taking items until a step needs the output register,
// then holds that step, and takes nothing further, until the waiting transfer.
// Reset sets span_min_start to 800 and leaves the filler idle, so a step then
// gives done. span_min_start sits at APB address 0 and may be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module triangle_scanline_filler
  import tsf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready,
  // Item channel
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic                         cmd,
  input  logic signed [COORD_BITS-1:0] vert_a_x,
  input  logic signed [COORD_BITS-1:0] vert_a_y,
  input  logic signed [COORD_BITS-1:0] vert_b_x,
  input  logic signed [COORD_BITS-1:0] vert_b_y,
  input  logic signed [COORD_BITS-1:0] vert_c_x,
  input  logic signed [COORD_BITS-1:0] vert_c_y,
  input  logic [COLOR_W-1:0]           fill_color,
  // Result channel
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic                         pixel_valid,
  output logic                         fill_done,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_W-1:0]           pixel_color
);

  localparam int CW     = COORD_BITS;
  localparam int SPAN_W = ((COORD_BITS > SPAN_MIN_W) ? COORD_BITS : SPAN_MIN_W) + 1;
  localparam int IDX_W  = APB_ADDR_W - 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WORK,
    S_EDGE_GO,
    S_EDGE_WAIT
  } fill_state_t;

  fill_state_t state;

  // Configuration
  logic [SPAN_MIN_W-1:0] span_min_start;
  logic [IDX_W-1:0]      reg_idx;
  logic                  cfg_write;

  // Triangle and walk state
  logic signed [CW-1:0]  vx [3];
  logic signed [CW-1:0]  vy [3];
  logic [COLOR_W-1:0]    color_store;
  logic signed [CW-1:0]  row_now;
  logic signed [CW-1:0]  row_last;
  logic signed [CW-1:0]  column_now;
  logic signed [CW-1:0]  span_end;
  logic                  span_loaded;
  logic                  fill_active;

  // Per-row span search
  logic [1:0]               edge_sel;
  logic signed [SPAN_W-1:0] span_lo;
  logic signed [SPAN_W-1:0] span_hi;
  logic                     span_hit;
  logic signed [SPAN_W-1:0] lo_next;
  logic signed [SPAN_W-1:0] hi_next;
  logic                     hit_next;
  logic signed [SPAN_W-1:0] edge_x_ext;

  // Edge unit connection
  logic signed [CW-1:0] e_xa;
  logic signed [CW-1:0] e_ya;
  logic signed [CW-1:0] e_xb;
  logic signed [CW-1:0] e_yb;
  logic signed [CW-1:0] edge_x;
  edge_rsp_t            edge_rsp;

  // Start-time row range
  logic signed [CW-1:0] in_ylo;
  logic signed [CW-1:0] in_yhi;

  logic item_xfer;
  logic out_free;
  logic out_load;

  assign pready     = 1'b1;
  assign reg_idx    = paddr[APB_ADDR_W-1:2];
  assign cfg_write  = psel && penable && pwrite && pready;
  assign item_ready = (state == S_IDLE);
  assign item_xfer  = item_valid && item_ready;

  // The output register may be refilled in the cycle its transfer happens.
  assign out_free = !result_valid || result_ready;
  assign out_load = (state == S_WORK) && (!fill_active || span_loaded) && out_free;

  always_comb begin
    prdata = '0;
    if (reg_idx == IDX_W'(REG_SPAN_MIN_START)) begin
      prdata = APB_DATA_W'(span_min_start);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_min_start <= SPAN_START_RESET;
    end else if (cfg_write && (reg_idx == IDX_W'(REG_SPAN_MIN_START))) begin
      span_min_start <= pwdata[SPAN_MIN_W-1:0];
    end
  end

  always_comb begin
    in_ylo = vert_a_y;
    in_yhi = vert_a_y;
    if (vert_b_y < in_ylo) in_ylo = vert_b_y;
    if (vert_c_y < in_ylo) in_ylo = vert_c_y;
    if (vert_b_y > in_yhi) in_yhi = vert_b_y;
    if (vert_c_y > in_yhi) in_yhi = vert_c_y;
  end

  always_comb begin
    unique case (edge_sel)
      EDGE_AB: begin
        e_xa = vx[0]; e_ya = vy[0]; e_xb = vx[1]; e_yb = vy[1];
      end
      EDGE_AC: begin
        e_xa = vx[0]; e_ya = vy[0]; e_xb = vx[2]; e_yb = vy[2];
      end
      default: begin
        e_xa = vx[1]; e_ya = vy[1]; e_xb = vx[2]; e_yb = vy[2];
      end
    endcase
  end

  tsf_edge #(
    .COORD_BITS(COORD_BITS)
  ) u_edge (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_EDGE_GO),
    .xa    (e_xa),
    .ya    (e_ya),
    .xb    (e_xb),
    .yb    (e_yb),
    .y     (row_now),
    .rsp   (edge_rsp),
    .x     (edge_x)
  );

  // Fold the latest edge result into the running span of the row.
  always_comb begin
    edge_x_ext = SPAN_W'(edge_x);
    lo_next    = span_lo;
    hi_next    = span_hi;
    hit_next   = span_hit;
    if (edge_rsp.hit) begin
      hit_next = 1'b1;
      if (edge_x_ext < span_lo) lo_next = edge_x_ext;
      if (edge_x_ext > span_hi) hi_next = edge_x_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      fill_active  <= 1'b0;
      span_loaded  <= 1'b0;
      edge_sel     <= EDGE_AB;
      span_hit     <= 1'b0;
      vx[0]        <= '0;
      vx[1]        <= '0;
      vx[2]        <= '0;
      vy[0]        <= '0;
      vy[1]        <= '0;
      vy[2]        <= '0;
      color_store  <= '0;
      row_now      <= '0;
      row_last     <= '0;
      column_now   <= '0;
      span_end     <= '0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_xfer) begin
            if (cmd == CMD_START) begin
              vx[0]       <= vert_a_x;
              vy[0]       <= vert_a_y;
              vx[1]       <= vert_b_x;
              vy[1]       <= vert_b_y;
              vx[2]       <= vert_c_x;
              vy[2]       <= vert_c_y;
              color_store <= fill_color;
              row_now     <= in_ylo;
              row_last    <= in_yhi;
              column_now  <= '0;
              span_end    <= '0;
              span_loaded <= 1'b0;
              fill_active <= 1'b1;
            end else begin
              state <= S_WORK;
            end
          end
        end
        S_WORK: begin
          if (!fill_active) begin
            if (out_load) begin
              pixel_valid <= 1'b0;
              fill_done   <= 1'b1;
              pixel_x     <= '0;
              pixel_y     <= '0;
              pixel_color <= '0;
              state       <= S_IDLE;
            end
          end else if (span_loaded) begin
            if (out_load) begin
              pixel_valid <= 1'b1;
              fill_done   <= 1'b0;
              pixel_x     <= column_now;
              pixel_y     <= row_now;
              pixel_color <= color_store;
              if (column_now >= span_end) begin
                span_loaded <= 1'b0;
                if (row_now >= row_last) begin
                  fill_active <= 1'b0;
                end else begin
                  row_now <= row_now + 1'b1;
                end
              end else begin
                column_now <= column_now + 1'b1;
              end
              state <= S_IDLE;
            end
          end else begin
            span_lo  <= SPAN_W'(span_min_start);
            span_hi  <= '0;
            span_hit <= 1'b0;
            edge_sel <= EDGE_AB;
            state    <= S_EDGE_GO;
          end
        end
        S_EDGE_GO: begin
          state <= S_EDGE_WAIT;
        end
        S_EDGE_WAIT: begin
          if (edge_rsp.done) begin
            span_lo  <= lo_next;
            span_hi  <= hi_next;
            span_hit <= hit_next;
            if (edge_sel == EDGE_BC) begin
              // A spanned row always has lo <= hi, and both fit the coordinate.
              if (hit_next) begin
                column_now  <= lo_next[CW-1:0];
                span_end    <= hi_next[CW-1:0];
                span_loaded <= 1'b1;
              end else if (row_now >= row_last) begin
                fill_active <= 1'b0;
              end else begin
                row_now <= row_now + 1'b1;
              end
              state <= S_WORK;
            end else begin
              edge_sel <= edge_sel + 1'b1;
              state    <= S_EDGE_GO;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/tsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_checker
// Port-level checks for the triangle scanline filler, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_scanline_filler_assert.svh"

module tsf_checker
  import tsf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_ready,
  input logic                         cmd,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic                         pixel_valid,
  input logic                         fill_done,
  input logic signed [COORD_BITS-1:0] pixel_x,
  input logic signed [COORD_BITS-1:0] pixel_y,
  input logic [COLOR_W-1:0]           pixel_color
);

  logic                            start_xfer;
  logic                            result_stall;
  logic                            zero_fields;
  logic [2*COORD_BITS+COLOR_W+2:0] held_fields;

  assign start_xfer   = item_valid && item_ready && (cmd == CMD_START) && !result_valid;
  assign result_stall = result_valid && !result_ready;
  assign zero_fields  = (pixel_x == '0) && (pixel_y == '0) && (pixel_color == '0);
  assign held_fields  = {result_valid, pixel_valid, fill_done, pixel_x, pixel_y, pixel_color};

  // Every result is either a pixel or the done marker.
  `TSF_ASSERT_IMPL(a_kind_exclusive, result_valid, pixel_valid != fill_done, "result kind bad")

  // A done result carries zero coordinates and color.
  `TSF_ASSERT_IMPL(a_done_zero, result_valid && fill_done, zero_fields, "done result not zero")

  // A start taken while no result waits leaves the result channel quiet.
  `TSF_ASSERT_NEXT(a_start_silent, start_xfer, !result_valid, "start produced a result")

  // A stalled result stays valid and keeps every field.
  `TSF_ASSERT_NEXT(a_stall_hold, result_stall, $stable(held_fields), "stalled result changed")

endmodule

bind triangle_scanline_filler tsf_checker #(.COORD_BITS(COORD_BITS)) u_tsf_checker (.*);
